// ----- rtl/core/m3hp_pkg.sv -----
// Shared types, constants and lookup tables for the Layer III header parser.
package m3hp_pkg;

    localparam int unsigned WordW  = 32;
    localparam int unsigned KbpsW  = 9;
    localparam int unsigned HzW    = 16;
    localparam int unsigned SpfW   = 11;
    localparam int unsigned LenW   = 11;
    localparam int unsigned MulW   = 9;
    // kbps * multiplier stays below 2^17 (largest is 320 * 160 = 51200)
    localparam int unsigned ProdW  = 17;
    // floor(x / 49) == (x * Recip49) >> Shift49 for every x below 2^17
    localparam int unsigned RecipW  = 18;
    localparam int unsigned Shift49 = 23;
    localparam logic [RecipW-1:0] Recip49 = 18'd171197;
    localparam int unsigned QuotW   = ProdW + RecipW;

    localparam logic [WordW-1:0] SYNC_MASK = 32'hFFE0_0000;

    localparam logic [1:0] VER_25  = 2'd0;
    localparam logic [1:0] VER_RSV = 2'd1;
    localparam logic [1:0] VER_2   = 2'd2;
    localparam logic [1:0] VER_1   = 2'd3;
    localparam logic [1:0] LAYER_3 = 2'd1;
    localparam logic [1:0] SRI_441 = 2'd0;
    localparam logic [1:0] SRI_48  = 2'd1;
    localparam logic [1:0] SRI_32  = 2'd2;
    localparam logic [1:0] SRI_RSV = 2'd3;
    localparam logic [1:0] CHM_MONO = 2'd3;
    localparam logic [3:0] BRI_FREE = 4'd0;
    localparam logic [3:0] BRI_BAD  = 4'd15;

    localparam logic [HzW-1:0]  HZ_44100 = 16'd44100;
    localparam logic [HzW-1:0]  HZ_48000 = 16'd48000;
    localparam logic [HzW-1:0]  HZ_32000 = 16'd32000;
    localparam logic [SpfW-1:0] SPF_V1   = 11'd1152;
    localparam logic [SpfW-1:0] SPF_V2   = 11'd576;

    // Divisor applied after kbps * multiplier
    typedef enum logic [1:0] {
        DIV_1,
        DIV_2,
        DIV_49
    } t_div;

    typedef struct packed {
        logic             ok;
        logic [KbpsW-1:0] kbps;
        logic [HzW-1:0]   hz;
        logic [SpfW-1:0]  spf;
        logic             v1;
        logic             mono;
        logic             pad;
        logic [MulW-1:0]  mul;
        t_div             div;
    } t_dec;

    function automatic logic [KbpsW-1:0] f_rate_v1(input logic [3:0] bri);
        logic [KbpsW-1:0] r;
        unique case (bri)
            4'd1:    r = 9'd32;
            4'd2:    r = 9'd40;
            4'd3:    r = 9'd48;
            4'd4:    r = 9'd56;
            4'd5:    r = 9'd64;
            4'd6:    r = 9'd80;
            4'd7:    r = 9'd96;
            4'd8:    r = 9'd112;
            4'd9:    r = 9'd128;
            4'd10:   r = 9'd160;
            4'd11:   r = 9'd192;
            4'd12:   r = 9'd224;
            4'd13:   r = 9'd256;
            4'd14:   r = 9'd320;
            default: r = 9'd0;
        endcase
        return r;
    endfunction

    function automatic logic [KbpsW-1:0] f_rate_v2(input logic [3:0] bri);
        logic [KbpsW-1:0] r;
        unique case (bri)
            4'd1:    r = 9'd8;
            4'd2:    r = 9'd16;
            4'd3:    r = 9'd24;
            4'd4:    r = 9'd32;
            4'd5:    r = 9'd40;
            4'd6:    r = 9'd48;
            4'd7:    r = 9'd56;
            4'd8:    r = 9'd64;
            4'd9:    r = 9'd80;
            4'd10:   r = 9'd96;
            4'd11:   r = 9'd112;
            4'd12:   r = 9'd128;
            4'd13:   r = 9'd144;
            4'd14:   r = 9'd160;
            default: r = 9'd0;
        endcase
        return r;
    endfunction

endpackage

// ----- rtl/core/m3hp_decode.sv -----
// Header field decode, validity checks and table lookups.
module m3hp_decode (
    input  logic [m3hp_pkg::WordW-1:0] i_word,
    output m3hp_pkg::t_dec             o_dec
);
    import m3hp_pkg::*;

    logic [1:0] ver;
    logic [1:0] lay;
    logic [3:0] bri;
    logic [1:0] sri;
    logic       ok;
    logic [HzW-1:0] base_hz;

    assign ver = i_word[20:19];
    assign lay = i_word[18:17];
    assign bri = i_word[15:12];
    assign sri = i_word[11:10];

    assign ok = ((i_word & SYNC_MASK) == SYNC_MASK) && (ver != VER_RSV) &&
                (lay == LAYER_3) && (bri != BRI_FREE) && (bri != BRI_BAD) &&
                (sri != SRI_RSV);

    always_comb begin
        unique case (sri)
            SRI_441: base_hz = HZ_44100;
            SRI_48:  base_hz = HZ_48000;
            SRI_32:  base_hz = HZ_32000;
            default: base_hz = '0;
        endcase
    end

    // len = floor(kbps * mul / div), with mul/div = 144000/base for MPEG-1
    // and MPEG-2, and 288000/base for MPEG-2.5
    always_comb begin
        o_dec = '0;
        o_dec.div = DIV_1;
        if (ok) begin
            o_dec.ok   = 1'b1;
            o_dec.v1   = (ver == VER_1);
            o_dec.kbps = (ver == VER_1) ? f_rate_v1(bri) : f_rate_v2(bri);
            o_dec.spf  = (ver == VER_1) ? SPF_V1 : SPF_V2;
            o_dec.mono = (i_word[7:6] == CHM_MONO);
            o_dec.pad  = i_word[9];
            unique case (ver)
                VER_2:   o_dec.hz = base_hz >> 1;
                VER_25:  o_dec.hz = base_hz >> 2;
                default: o_dec.hz = base_hz;
            endcase
            unique case (sri)
                SRI_441: begin
                    o_dec.mul = (ver == VER_25) ? 9'd320 : 9'd160;
                    o_dec.div = DIV_49;
                end
                SRI_48: begin
                    o_dec.mul = (ver == VER_25) ? 9'd6 : 9'd3;
                    o_dec.div = DIV_1;
                end
                default: begin
                    o_dec.mul = 9'd9;
                    o_dec.div = (ver == VER_25) ? DIV_1 : DIV_2;
                end
            endcase
        end
    end

endmodule

// ----- rtl/core/mp3_layer3_header_parse_top.sv -----
// Top level of the pipelined MPEG audio Layer III frame header parser.
//
// Usage:
//   Input channel: i_valid / o_stall carry one 32-bit header word per beat
//   (first stream byte in bits 31..24). A beat is taken at a rising edge
//   with i_valid high and o_stall low.
//   Output channel: o_valid / i_stall carry one result per input beat:
//   o_valid_res flags a legal Layer III header; bitrate, sample rate,
//   samples per frame, frame length (with padding) and the MPEG-1 and
//   mono flags follow. A rejected header returns all fields zero.
//   Path: decode, multiply, reciprocal and output registers in turn.
//   Throughput: one beat per cycle when not stalled; slowest stage is the
//   17x18-bit reciprocal multiply dividing by 49 for the 44.1 kHz family.
//   Stall: each stage holds while its successor is full and cannot move,
//   so bubbles collapse and o_stall rises only when all four stages are
//   full and i_stall is high. Nothing is dropped or repeated.
//   Reset (i_rst_n low, synchronous): clear all stage valid bits; the
//   block is empty and ready on the next cycle.
module mp3_layer3_header_parse_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [m3hp_pkg::WordW-1:0]    i_header_word,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic                          o_valid_res,
    output logic [m3hp_pkg::KbpsW-1:0]    o_bitrate_kbps,
    output logic [m3hp_pkg::HzW-1:0]      o_sample_rate_hz,
    output logic [m3hp_pkg::SpfW-1:0]     o_samples_per_frame,
    output logic [m3hp_pkg::LenW-1:0]     o_frame_bytes,
    output logic                          o_is_mpeg1,
    output logic                          o_is_mono
);
    import m3hp_pkg::*;

    // Stage enables: a stage loads when empty or when its successor loads
    logic en1, en2, en3, en4;

    t_dec dec;

    // Stage 1: decoded header
    logic r1_v;
    t_dec r1_d;
    // Stage 2: kbps * multiplier
    logic r2_v;
    t_dec r2_d;
    logic [ProdW-1:0] r2_x;
    // Stage 3: reciprocal product for the divide by 49
    logic r3_v;
    t_dec r3_d;
    logic [ProdW-1:0] r3_x;
    logic [QuotW-1:0] r3_q;
    // Stage 4: output register
    logic r4_v;

    logic [2*MulW-1:0] n_x;
    logic [QuotW-1:0]  n_q;
    logic [LenW-1:0]   len_raw;
    logic [LenW-1:0]   n_len;

    assign en4 = !r4_v || !i_stall;
    assign en3 = !r3_v || en4;
    assign en2 = !r2_v || en3;
    assign en1 = !r1_v || en2;
    assign o_stall = !en1;
    assign o_valid = r4_v;

    m3hp_decode u_decode (
        .i_word (i_header_word),
        .o_dec  (dec)
    );

    assign n_x = r1_d.kbps * r1_d.mul;
    assign n_q = r2_x * Recip49;

    // Select the quotient by divisor, then add the padding byte
    always_comb begin
        unique case (r3_d.div)
            DIV_2:   len_raw = r3_x[LenW:1];
            DIV_49:  len_raw = r3_q[Shift49 +: LenW];
            default: len_raw = r3_x[LenW-1:0];
        endcase
        n_len = len_raw + LenW'(r3_d.pad);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
        end else begin
            if (en1) r1_v <= i_valid;
            if (en2) r2_v <= r1_v;
            if (en3) r3_v <= r2_v;
            if (en4) r4_v <= r3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r1_d <= dec;
        end
        if (en2) begin
            r2_d <= r1_d;
            r2_x <= n_x[ProdW-1:0];
        end
        if (en3) begin
            r3_d <= r2_d;
            r3_x <= r2_x;
            r3_q <= n_q;
        end
        if (en4) begin
            o_valid_res         <= r3_d.ok;
            o_bitrate_kbps      <= r3_d.kbps;
            o_sample_rate_hz    <= r3_d.hz;
            o_samples_per_frame <= r3_d.spf;
            o_frame_bytes       <= n_len;
            o_is_mpeg1          <= r3_d.v1;
            o_is_mono           <= r3_d.mono;
        end
    end

endmodule
